[src/lgvf_pkg.sv]
// lgvf_pkg: shared constants, codes and types of the log-garch volatility filter
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none

package lgvf_pkg;

  // recursion orders (1 or 2)
  localparam int unsigned VolOrder   = 2;
  localparam int unsigned ShockOrder = 2;

  // field and port widths
  localparam int unsigned DataW   = 32;
  localparam int unsigned CfgIdxW = 4;

  // ln(2) in unsigned q32
  localparam logic [31:0] Ln2Q32 = 32'd2977044472;

  // -40*ln(2) in q32, lower bound for lv/2 below which sigma is set to zero
  localparam logic signed [47:0] ExpFloor = -48'sd119081778880;

  // taylor terms of exp and last odd divisor of the atanh series
  localparam logic [4:0] ExpTerms = 5'd14;
  localparam logic [4:0] LogLastN = 5'd21;

  // divider pass lengths in bits
  localparam logic [6:0] DivBitsExp = 7'd33;
  localparam logic [6:0] DivBitsZ   = 7'd64;
  localparam logic [6:0] DivBitsLog = 7'd32;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_MEAN      = 4'd0,
    REG_INTERCEPT = 4'd1,
    REG_VOL_ONE   = 4'd2,
    REG_VOL_TWO   = 4'd3,
    REG_SHOCK_ONE = 4'd4,
    REG_SHOCK_TWO = 4'd5,
    REG_EXP_SHOCK = 4'd6,
    REG_INIT_LV   = 4'd7
  } reg_idx_e;

  // sequencer states, one-hot
  typedef enum logic [15:0] {
    ST_IDLE      = 16'h0001,
    ST_MAC       = 16'h0002,
    ST_LV        = 16'h0004,
    ST_EXP_RED   = 16'h0008,
    ST_EXP_MUL   = 16'h0010,
    ST_EXP_DIV   = 16'h0020,
    ST_EXP_ROUND = 16'h0040,
    ST_LOG_INIT  = 16'h0080,
    ST_LOG_NORM  = 16'h0100,
    ST_LOG_ZDIV  = 16'h0200,
    ST_LOG_Z2    = 16'h0400,
    ST_LOG_DIV   = 16'h0800,
    ST_LOG_MUL   = 16'h1000,
    ST_LOG_FIN   = 16'h2000,
    ST_SHOCK     = 16'h4000,
    ST_DONE      = 16'h8000
  } state_e;

endpackage : lgvf_pkg

`default_nettype wire

[src/lgvf_in_if.sv]
// lgvf_in_if: input sample channel, valid/ready with sample payload
// depends on lgvf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface lgvf_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [lgvf_pkg::DataW-1:0] sample;
  logic                           series_start;

  modport source (output valid, output sample, output series_start, input ready);
  modport sink   (input valid, input sample, input series_start, output ready);
endinterface : lgvf_in_if

`default_nettype wire

[src/lgvf_out_if.sv]
// lgvf_out_if: result channel, valid/ready with volatility payload
// depends on lgvf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface lgvf_out_if;
  logic                           valid;
  logic                           ready;
  logic [lgvf_pkg::DataW-1:0]        sigma;
  logic signed [lgvf_pkg::DataW-1:0] log_variance;
  logic                           saturated;

  modport source (output valid, output sigma, output log_variance, output saturated,
                  input ready);
  modport sink   (input valid, input sigma, input log_variance, input saturated,
                  output ready);
endinterface : lgvf_out_if

`default_nettype wire

[src/log_garch_volatility_filter.sv]
// log_garch_volatility_filter: log-garch(2,2) recursion on a shared multiplier and divider
// depends on lgvf_pkg, lgvf_in_if, lgvf_out_if
// per sample: the weighted sum, then exp by range reduction and 14 taylor divisions,
//   then log by an atanh argument division and 11 series divisions, both on the
//   one-bit-per-cycle divider
// the next sample is taken once the result moves to the output register, which holds
//   it until its transfer
// reset: asynchronous active low; clears registers, histories and output valid
`timescale 1ns / 1ps
`default_nettype none

module log_garch_volatility_filter (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  lgvf_in_if.sink                                in_ch,
  lgvf_out_if.source                             out_ch,
  input  wire logic                              cfg_we_i,
  input  wire logic [lgvf_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [lgvf_pkg::DataW-1:0]        cfg_data_i
);

  lgvf_pkg::state_e state_q;

  // configuration
  logic signed [31:0] mean_q, icpt_q, v1_q, v2_q, s1_q, s2_q, els_q, initlv_q;

  // histories, index zero newest
  logic signed [31:0] lvh0_q, lvh1_q, shh0_q, shh1_q;

  // item working registers
  logic signed [31:0] x_q, lv_q, lnsq_q;
  logic signed [49:0] acc_q;
  logic [1:0]         idx_q;
  logic               sat_q, wait_q;
  logic [47:0]        r_q;
  logic signed [6:0]  k_q;
  logic [33:0]        esum_q;
  logic [4:0]         n_q;
  logic [31:0]        sig_q;
  logic [31:0]        norm_q;
  logic [4:0]         m_q;
  logic [31:0]        z2_q, lterm_q;
  logic [32:0]        lsum_q;

  // shared multiplier
  logic signed [34:0] mul_a_q, mul_b_q;
  logic signed [69:0] prod_q;

  // shared restoring divider
  logic [63:0] dvd_q, quo_q;
  logic [34:0] dvs_q, rem_q;
  logic [6:0]  cnt_q;

  // output register
  logic        out_valid_q;
  logic [31:0] out_sigma_q;
  logic signed [31:0] out_lv_q;
  logic        out_sat_q;

  // divider step
  logic [35:0] rem_sh;
  logic        div_ge;
  logic [35:0] rem_sub;
  assign rem_sh  = {rem_q, dvd_q[63]};
  assign div_ge  = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  // history values as seen by the first product of a new item
  logic signed [31:0] lvh0_in, lvh1_in, shh0_in, shh1_in;
  assign lvh0_in = in_ch.series_start ? initlv_q : lvh0_q;
  assign lvh1_in = in_ch.series_start ? initlv_q : lvh1_q;
  assign shh0_in = in_ch.series_start ? 32'sd0   : shh0_q;
  assign shh1_in = in_ch.series_start ? 32'sd0   : shh1_q;

  // weight for each product, unused orders forced to zero
  logic signed [31:0] w_nxt, h_nxt;
  logic [1:0]         idx_nxt;
  assign idx_nxt = idx_q + 2'd1;
  always_comb begin
    case (idx_nxt)
      2'd1:    begin
        w_nxt = (lgvf_pkg::VolOrder >= 2) ? v2_q : 32'sd0;
        h_nxt = lvh1_q;
      end
      2'd2:    begin
        w_nxt = s1_q;
        h_nxt = shh0_q;
      end
      2'd3:    begin
        w_nxt = (lgvf_pkg::ShockOrder >= 2) ? s2_q : 32'sd0;
        h_nxt = shh1_q;
      end
      default: begin
        w_nxt = v1_q;
        h_nxt = lvh0_q;
      end
    endcase
  end

  // log-variance clamp and exp range check
  logic signed [31:0] lv_c;
  logic               lv_clamped;
  logic signed [47:0] y_c;
  always_comb begin
    lv_clamped = 1'b1;
    if (acc_q > 50'sd2147483647) begin
      lv_c = 32'sh7FFFFFFF;
    end else if (acc_q < -50'sd2147483648) begin
      lv_c = 32'sh80000000;
    end else begin
      lv_c       = acc_q[31:0];
      lv_clamped = 1'b0;
    end
    y_c = {lv_c[31], lv_c, 15'd0};
  end

  // final rounding of the exp sum by 2^(16-k)
  logic [6:0]  s_w;
  logic [56:0] rnd_w;
  assign s_w   = 7'd16 - k_q;
  assign rnd_w = ({23'd0, esum_q} + (57'd1 << (s_w[5:0] - 6'd1))) >> s_w[5:0];

  // difference from the mean
  logic signed [32:0] d_c;
  logic [32:0]        ad_c;
  assign d_c  = {x_q[31], x_q} - {mean_q[31], mean_q};
  assign ad_c = d_c[32] ? 33'(-d_c) : 33'(d_c);

  // log assembly
  logic signed [63:0] lnv_c;
  assign lnv_c = prod_q[63:0] + {30'd0, lsum_q, 1'b0};

  // innovation clamp
  logic signed [33:0] sh_c;
  assign sh_c = {{2{lnsq_q[31]}}, lnsq_q} - {{2{lv_q[31]}}, lv_q} - {{2{els_q[31]}}, els_q};

  assign in_ch.ready         = (state_q == lgvf_pkg::ST_IDLE);
  assign out_ch.valid        = out_valid_q;
  assign out_ch.sigma        = out_sigma_q;
  assign out_ch.log_variance = out_lv_q;
  assign out_ch.saturated    = out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lgvf_pkg::ST_IDLE;
      mean_q      <= '0;
      icpt_q      <= '0;
      v1_q        <= '0;
      v2_q        <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
      els_q       <= '0;
      initlv_q    <= '0;
      lvh0_q      <= '0;
      lvh1_q      <= '0;
      shh0_q      <= '0;
      shh1_q      <= '0;
      x_q         <= '0;
      lv_q        <= '0;
      lnsq_q      <= '0;
      acc_q       <= '0;
      idx_q       <= '0;
      sat_q       <= 1'b0;
      wait_q      <= 1'b0;
      r_q         <= '0;
      k_q         <= '0;
      esum_q      <= '0;
      n_q         <= '0;
      sig_q       <= '0;
      norm_q      <= '0;
      m_q         <= '0;
      z2_q        <= '0;
      lterm_q     <= '0;
      lsum_q      <= '0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
      prod_q      <= '0;
      dvd_q       <= '0;
      quo_q       <= '0;
      dvs_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_sigma_q <= '0;
      out_lv_q    <= '0;
      out_sat_q   <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lgvf_pkg::REG_MEAN:      mean_q   <= cfg_data_i;
          lgvf_pkg::REG_INTERCEPT: icpt_q   <= cfg_data_i;
          lgvf_pkg::REG_VOL_ONE:   v1_q     <= cfg_data_i;
          lgvf_pkg::REG_VOL_TWO:   v2_q     <= cfg_data_i;
          lgvf_pkg::REG_SHOCK_ONE: s1_q     <= cfg_data_i;
          lgvf_pkg::REG_SHOCK_TWO: s2_q     <= cfg_data_i;
          lgvf_pkg::REG_EXP_SHOCK: els_q    <= cfg_data_i;
          lgvf_pkg::REG_INIT_LV:   initlv_q <= cfg_data_i;
          default: ;
        endcase
      end

      // multiplier runs every cycle
      prod_q <= mul_a_q * mul_b_q;

      // divider steps while a pass is open
      if (cnt_q != 7'd0) begin
        rem_q <= div_ge ? rem_sub[34:0] : rem_sh[34:0];
        quo_q <= {quo_q[62:0], div_ge};
        dvd_q <= {dvd_q[62:0], 1'b0};
        cnt_q <= cnt_q - 7'd1;
      end

      // output transfer, a result handed over in the same cycle is loaded below
      if (out_valid_q && out_ch.ready && (state_q != lgvf_pkg::ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        lgvf_pkg::ST_IDLE: begin
          if (in_ch.valid) begin
            x_q     <= in_ch.sample;
            lvh0_q  <= lvh0_in;
            lvh1_q  <= lvh1_in;
            shh0_q  <= shh0_in;
            shh1_q  <= shh1_in;
            acc_q   <= 50'(icpt_q);
            idx_q   <= 2'd0;
            sat_q   <= 1'b0;
            mul_a_q <= 35'(v1_q);
            mul_b_q <= 35'(lvh0_in);
            wait_q  <= 1'b1;
            state_q <= lgvf_pkg::ST_MAC;
          end
        end

        // weighted sum of the histories, one product per pass
        lgvf_pkg::ST_MAC: begin
          if (wait_q) begin
            wait_q <= 1'b0;
          end else begin
            acc_q <= acc_q + prod_q[65:16];
            if (idx_q == 2'd3) begin
              state_q <= lgvf_pkg::ST_LV;
            end else begin
              idx_q   <= idx_nxt;
              mul_a_q <= 35'(w_nxt);
              mul_b_q <= 35'(h_nxt);
              wait_q  <= 1'b1;
            end
          end
        end

        // clamp and set up the range reduction of lv/2
        lgvf_pkg::ST_LV: begin
          lv_q <= lv_c;
          if (lv_clamped) sat_q <= 1'b1;
          if (y_c < lgvf_pkg::ExpFloor) begin
            sig_q   <= '0;
            state_q <= lgvf_pkg::ST_LOG_INIT;
          end else begin
            r_q     <= 48'(y_c - lgvf_pkg::ExpFloor);
            k_q     <= -7'sd40;
            state_q <= lgvf_pkg::ST_EXP_RED;
          end
        end

        // subtract ln2 until the remainder is below it
        lgvf_pkg::ST_EXP_RED: begin
          if (r_q >= {16'd0, lgvf_pkg::Ln2Q32}) begin
            if (k_q == 7'sd15) begin
              sat_q   <= 1'b1;
              sig_q   <= 32'hFFFFFFFF;
              state_q <= lgvf_pkg::ST_LOG_INIT;
            end else begin
              r_q <= r_q - {16'd0, lgvf_pkg::Ln2Q32};
              k_q <= k_q + 7'sd1;
            end
          end else begin
            esum_q  <= 34'h1_0000_0000;
            n_q     <= 5'd1;
            mul_a_q <= 35'sh1_0000_0000;
            mul_b_q <= {3'd0, r_q[31:0]};
            wait_q  <= 1'b1;
            state_q <= lgvf_pkg::ST_EXP_MUL;
          end
        end

        // taylor term times r, then divide by n
        lgvf_pkg::ST_EXP_MUL: begin
          if (wait_q) begin
            wait_q <= 1'b0;
          end else begin
            dvd_q   <= {prod_q[64:32], 31'd0};
            dvs_q   <= {30'd0, n_q};
            rem_q   <= '0;
            quo_q   <= '0;
            cnt_q   <= lgvf_pkg::DivBitsExp;
            state_q <= lgvf_pkg::ST_EXP_DIV;
          end
        end

        lgvf_pkg::ST_EXP_DIV: begin
          if (cnt_q == 7'd0) begin
            esum_q  <= esum_q + {1'b0, quo_q[32:0]};
            if (n_q == lgvf_pkg::ExpTerms) begin
              state_q <= lgvf_pkg::ST_EXP_ROUND;
            end else begin
              n_q     <= n_q + 5'd1;
              mul_a_q <= {2'd0, quo_q[32:0]};
              mul_b_q <= {3'd0, r_q[31:0]};
              wait_q  <= 1'b1;
              state_q <= lgvf_pkg::ST_EXP_MUL;
            end
          end
        end

        // scale by 2^k with round half up
        lgvf_pkg::ST_EXP_ROUND: begin
          if (rnd_w[56:32] != 25'd0) begin
            sat_q <= 1'b1;
            sig_q <= 32'hFFFFFFFF;
          end else begin
            sig_q <= rnd_w[31:0];
          end
          state_q <= lgvf_pkg::ST_LOG_INIT;
        end

        // log of the squared deviation
        lgvf_pkg::ST_LOG_INIT: begin
          if (d_c == 33'sd0) begin
            sat_q   <= 1'b1;
            lnsq_q  <= 32'sh80000000;
            state_q <= lgvf_pkg::ST_SHOCK;
          end else begin
            norm_q  <= ad_c[31:0];
            m_q     <= 5'd31;
            state_q <= lgvf_pkg::ST_LOG_NORM;
          end
        end

        // normalize one bit a cycle, then z = (M-1)/(M+1)
        lgvf_pkg::ST_LOG_NORM: begin
          if (!norm_q[31]) begin
            norm_q <= {norm_q[30:0], 1'b0};
            m_q    <= m_q - 5'd1;
          end else begin
            dvd_q   <= {norm_q[30:0], 1'b0, 32'd0};
            dvs_q   <= {2'd0, norm_q, 1'b0} + 35'h1_0000_0000;
            rem_q   <= '0;
            quo_q   <= '0;
            cnt_q   <= lgvf_pkg::DivBitsZ;
            state_q <= lgvf_pkg::ST_LOG_ZDIV;
          end
        end

        lgvf_pkg::ST_LOG_ZDIV: begin
          if (cnt_q == 7'd0) begin
            mul_a_q <= {3'd0, quo_q[31:0]};
            mul_b_q <= {3'd0, quo_q[31:0]};
            lterm_q <= quo_q[31:0];
            wait_q  <= 1'b1;
            state_q <= lgvf_pkg::ST_LOG_Z2;
          end
        end

        lgvf_pkg::ST_LOG_Z2: begin
          if (wait_q) begin
            wait_q <= 1'b0;
          end else begin
            z2_q    <= prod_q[63:32];
            lsum_q  <= '0;
            n_q     <= 5'd1;
            dvd_q   <= {lterm_q, 32'd0};
            dvs_q   <= 35'd1;
            rem_q   <= '0;
            quo_q   <= '0;
            cnt_q   <= lgvf_pkg::DivBitsLog;
            state_q <= lgvf_pkg::ST_LOG_DIV;
          end
        end

        // odd series term / n, then term times z^2
        lgvf_pkg::ST_LOG_DIV: begin
          if (cnt_q == 7'd0) begin
            lsum_q <= lsum_q + {1'b0, quo_q[31:0]};
            wait_q <= 1'b1;
            if (n_q == lgvf_pkg::LogLastN) begin
              // signed exponent m - 16
              mul_a_q <= 35'($signed(6'({1'b0, m_q} - 6'd16)));
              mul_b_q <= {3'd0, lgvf_pkg::Ln2Q32};
              state_q <= lgvf_pkg::ST_LOG_FIN;
            end else begin
              mul_a_q <= {3'd0, lterm_q};
              mul_b_q <= {3'd0, z2_q};
              state_q <= lgvf_pkg::ST_LOG_MUL;
            end
          end
        end

        lgvf_pkg::ST_LOG_MUL: begin
          if (wait_q) begin
            wait_q <= 1'b0;
          end else begin
            lterm_q <= prod_q[63:32];
            n_q     <= n_q + 5'd2;
            dvd_q   <= {prod_q[63:32], 32'd0};
            dvs_q   <= {30'd0, n_q + 5'd2};
            rem_q   <= '0;
            quo_q   <= '0;
            cnt_q   <= lgvf_pkg::DivBitsLog;
            state_q <= lgvf_pkg::ST_LOG_DIV;
          end
        end

        // exponent times ln2 plus twice the series, floored to q16.16
        lgvf_pkg::ST_LOG_FIN: begin
          if (wait_q) begin
            wait_q <= 1'b0;
          end else begin
            lnsq_q  <= lnv_c[46:15];
            state_q <= lgvf_pkg::ST_SHOCK;
          end
        end

        // new innovation and history shift
        lgvf_pkg::ST_SHOCK: begin
          lvh1_q <= lvh0_q;
          lvh0_q <= lv_q;
          shh1_q <= shh0_q;
          if (sh_c > 34'sd2147483647) begin
            shh0_q <= 32'sh7FFFFFFF;
            sat_q  <= 1'b1;
          end else if (sh_c < -34'sd2147483648) begin
            shh0_q <= 32'sh80000000;
            sat_q  <= 1'b1;
          end else begin
            shh0_q <= sh_c[31:0];
          end
          state_q <= lgvf_pkg::ST_DONE;
        end

        // hand the result to the output register
        lgvf_pkg::ST_DONE: begin
          if (!out_valid_q || out_ch.ready) begin
            out_valid_q <= 1'b1;
            out_sigma_q <= sig_q;
            out_lv_q    <= lv_q;
            out_sat_q   <= sat_q;
            state_q     <= lgvf_pkg::ST_IDLE;
          end
        end

        default: state_q <= lgvf_pkg::ST_IDLE;
      endcase
    end
  end

endmodule : log_garch_volatility_filter

`default_nettype wire
